### design/sha1md_pkg.sv
// Shared types and constants for the SHA-1 message digest block.
// No dependencies; imported by every module in design/.
package sha1md_pkg;

    // Input word: one message byte slot plus end-of-message flag.
    typedef struct packed {
        logic       byte_valid;
        logic [7:0] data_byte;
        logic       last;
    } in_word_t;

    // Output word: one digest word.
    typedef struct packed {
        logic [31:0] digest_word;
        logic        word_last;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } state_t;

    // Which kind of block the compression engine is working on.
    typedef enum logic [1:0] {
        BLK_DATA,
        BLK_PAD,
        BLK_FINAL
    } blk_kind_t;

    localparam int unsigned NUM_WORDS  = 5;
    localparam int unsigned NUM_ROUNDS = 80;
    localparam logic [2:0]  LAST_WORD  = 3'd4;
    localparam logic [6:0]  LAST_ROUND = 7'd79;
    localparam logic [7:0]  PAD_BYTE   = 8'h80;

    localparam logic [31:0] INIT_CHAIN [NUM_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    // Round constant per group of 20 rounds.
    function automatic logic [31:0] round_k(input logic [1:0] phase);
        logic [31:0] k;
        unique case (phase)
            2'd0:    k = 32'h5A827999;
            2'd1:    k = 32'h6ED9EBA1;
            2'd2:    k = 32'h8F1BBCDC;
            default: k = 32'hCA62C1D6;
        endcase
        return k;
    endfunction

    // Controller -> datapath commands.
    typedef struct packed {
        logic       byte_wr;
        logic       pad;
        logic       len_wr;
        logic       len_clear;
        logic       round;
        logic [1:0] phase;
        logic       add;
        logic       reinit;
        logic [2:0] out_idx;
    } cmd_t;

    // Datapath -> controller status.
    typedef struct packed {
        logic pos_full;   // next byte completes the block
        logic pad_two;    // padding needs a second block
    } stat_t;

endpackage

### design/sha1md_datapath.sv
// SHA-1 datapath: block buffer / schedule window, working and chain words,
// byte and length counters. Depends on sha1md_pkg.
module sha1md_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sha1md_pkg::cmd_t     cmd,
    input  logic [7:0]           data_byte,
    output sha1md_pkg::stat_t    stat,
    output logic [31:0]          digest_word
);
    import sha1md_pkg::*;

    logic [31:0] w_reg     [16];
    logic [31:0] w_next    [16];
    logic [31:0] chain_reg [NUM_WORDS];
    logic [31:0] chain_next[NUM_WORDS];
    logic [31:0] work_reg  [NUM_WORDS];
    logic [31:0] work_next [NUM_WORDS];
    logic [5:0]  pos_reg, pos_next;
    logic [60:0] total_reg, total_next;

    logic [31:0] f_val, t_val, sched;
    logic [63:0] bit_len;

    assign bit_len = {total_reg, 3'b000};
    assign sched   = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];

    // round function
    always_comb begin
        unique case (cmd.phase)
            2'd0:    f_val = (work_reg[1] & work_reg[2]) | (~work_reg[1] & work_reg[3]);
            2'd2:    f_val = (work_reg[1] & work_reg[2]) | (work_reg[1] & work_reg[3])
                           | (work_reg[2] & work_reg[3]);
            default: f_val = work_reg[1] ^ work_reg[2] ^ work_reg[3];
        endcase
        t_val = {work_reg[0][26:0], work_reg[0][31:27]} + f_val + work_reg[4]
              + round_k(cmd.phase) + w_reg[0];
    end

    // block buffer: byte writes, padding, length, schedule shift
    always_comb begin
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < 16; i++) begin
            w_next[i] = w_reg[i];
        end
        priority if (cmd.byte_wr) begin
            for (int i = 0; i < 16; i++) begin
                for (int j = 0; j < 4; j++) begin
                    if (pos_reg == 6'(i * 4 + j)) begin
                        w_next[i][31 - 8 * j -: 8] = data_byte;
                    end
                end
            end
        end else if (cmd.pad) begin
            for (int i = 0; i < 16; i++) begin
                for (int j = 0; j < 4; j++) begin
                    p = 6'(i * 4 + j);
                    if (p == pos_reg) begin
                        w_next[i][31 - 8 * j -: 8] = PAD_BYTE;
                    end else if (p > pos_reg) begin
                        w_next[i][31 - 8 * j -: 8] = 8'h00;
                    end
                end
            end
        end else if (cmd.len_wr) begin
            if (cmd.len_clear) begin
                for (int i = 0; i < 14; i++) begin
                    w_next[i] = '0;
                end
            end
            w_next[14] = bit_len[63:32];
            w_next[15] = bit_len[31:0];
        end else if (cmd.round) begin
            for (int i = 0; i < 15; i++) begin
                w_next[i] = w_reg[i + 1];
            end
            w_next[15] = {sched[30:0], sched[31]};
        end
    end

    // working and chain words, counters
    always_comb begin
        for (int i = 0; i < NUM_WORDS; i++) begin
            chain_next[i] = chain_reg[i];
            work_next[i]  = work_reg[i];
        end
        pos_next   = pos_reg;
        total_next = total_reg;
        if (cmd.byte_wr) begin
            pos_next   = pos_reg + 6'd1;   // wraps to 0 on a full block
            total_next = total_reg + 61'd1;
        end
        priority if (cmd.reinit) begin
            for (int i = 0; i < NUM_WORDS; i++) begin
                chain_next[i] = INIT_CHAIN[i];
                work_next[i]  = INIT_CHAIN[i];
            end
            pos_next   = '0;
            total_next = '0;
        end else if (cmd.add) begin
            for (int i = 0; i < NUM_WORDS; i++) begin
                chain_next[i] = chain_reg[i] + work_reg[i];
                work_next[i]  = chain_reg[i] + work_reg[i];
            end
        end else if (cmd.round) begin
            work_next[0] = t_val;
            work_next[1] = work_reg[0];
            work_next[2] = {work_reg[1][1:0], work_reg[1][31:2]};
            work_next[3] = work_reg[2];
            work_next[4] = work_reg[3];
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 16; i++) begin
            w_reg[i] <= w_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_WORDS; i++) begin
                chain_reg[i] <= INIT_CHAIN[i];
                work_reg[i]  <= INIT_CHAIN[i];
            end
            pos_reg   <= '0;
            total_reg <= '0;
        end else begin
            for (int i = 0; i < NUM_WORDS; i++) begin
                chain_reg[i] <= chain_next[i];
                work_reg[i]  <= work_next[i];
            end
            pos_reg   <= pos_next;
            total_reg <= total_next;
        end
    end

    assign stat.pos_full = (pos_reg == 6'd63);
    assign stat.pad_two  = (pos_reg >= 6'd56);
    assign digest_word   = chain_reg[cmd.out_idx];

endmodule

### design/sha1md_ctrl.sv
// SHA-1 controller: sequences byte intake, padding, 80 rounds, chain add
// and digest readout. Depends on sha1md_pkg.
module sha1md_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              byte_valid,
    input  logic              last,
    input  logic              m_ready,
    input  sha1md_pkg::stat_t stat,
    output sha1md_pkg::cmd_t  cmd,
    output logic              s_ready,
    output logic              m_valid
);
    import sha1md_pkg::*;

    state_t     state_reg, state_next;
    blk_kind_t  kind_reg, kind_next;
    logic [6:0] round_reg, round_next;
    logic [2:0] idx_reg, idx_next;
    logic       last_pend_reg, last_pend_next;

    // next state
    always_comb begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        round_next     = round_reg;
        idx_next       = idx_reg;
        last_pend_next = last_pend_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    last_pend_next = last;
                    if (byte_valid && stat.pos_full) begin
                        state_next = ST_ROUND;
                        kind_next  = BLK_DATA;
                    end else if (last) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (stat.pad_two) begin
                    state_next = ST_ROUND;
                    kind_next  = BLK_PAD;
                end else begin
                    state_next = ST_LEN;
                    kind_next  = BLK_FINAL;
                end
            end
            ST_LEN: begin
                state_next = ST_ROUND;
                kind_next  = BLK_FINAL;
            end
            ST_ROUND: begin
                if (round_reg == LAST_ROUND) begin
                    round_next = '0;
                    state_next = ST_ADD;
                end else begin
                    round_next = round_reg + 7'd1;
                end
            end
            ST_ADD: begin
                unique case (kind_reg)
                    BLK_DATA:  state_next = last_pend_reg ? ST_PAD : ST_IDLE;
                    BLK_PAD:   state_next = ST_LEN;
                    default: begin
                        state_next = ST_OUT;
                        idx_next   = '0;
                    end
                endcase
            end
            ST_OUT: begin
                if (m_ready) begin
                    if (idx_reg == LAST_WORD) begin
                        state_next = ST_IDLE;
                        idx_next   = '0;
                    end else begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd           = '0;
        cmd.out_idx   = idx_reg;
        cmd.phase     = (round_reg < 7'd20) ? 2'd0 :
                        (round_reg < 7'd40) ? 2'd1 :
                        (round_reg < 7'd60) ? 2'd2 : 2'd3;
        s_ready       = 1'b0;
        m_valid       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.byte_wr = s_valid && byte_valid;
            end
            ST_PAD:   cmd.pad = 1'b1;
            ST_LEN: begin
                cmd.len_wr    = 1'b1;
                cmd.len_clear = (kind_reg == BLK_PAD);
            end
            ST_ROUND: cmd.round = 1'b1;
            ST_ADD:   cmd.add   = 1'b1;
            ST_OUT: begin
                m_valid    = 1'b1;
                cmd.reinit = m_ready && (idx_reg == LAST_WORD);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            kind_reg      <= BLK_DATA;
            round_reg     <= '0;
            idx_reg       <= '0;
            last_pend_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            round_reg     <= round_next;
            idx_reg       <= idx_next;
            last_pend_reg <= last_pend_next;
        end
    end

endmodule

### design/sha1_message_digest.sv
// SHA-1 message digest top level: controller plus datapath.
// Depends on sha1md_pkg, sha1md_ctrl, sha1md_datapath.
//
// Usage:
//  - Input channel s_*: one word per message byte (byte_valid = 1), or an
//    empty word (byte_valid = 0). A word with last = 1 ends the message; its
//    byte, if any, is part of the message. An empty last word hashes the
//    empty message when nothing came before.
//  - Output channel m_*: five 32-bit digest words, word 0 first; word_last
//    flags the fifth.
//  - Bytes are taken one per cycle while s_ready is high. The 64th byte of a
//    block drops s_ready while the block is compressed (80 rounds on one
//    shared round unit, then the chain add).
//  - After a last word: a pad step, then one padding block, or two when 56
//    or more bytes sit in the final block, each compressed, with a length
//    step before the final block's rounds, then the first digest word (plus
//    one more block compression first if the last byte itself filled a block).
//  - Digest words come straight from the chain registers; a stalled
//    receiver simply holds the block in readout, s_ready stays low until
//    the fifth word is taken, then the chain returns to its initial values.
//  - Reset (aresetn low, synchronous) restores the initial chain and clears
//    the byte and length counters; the block buffer needs no clearing.
module sha1_message_digest (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sha1md_pkg::in_word_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sha1md_pkg::out_word_t m_data
);
    import sha1md_pkg::*;

    cmd_t        cmd;
    stat_t       stat;
    logic [31:0] digest_word;

    sha1md_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .byte_valid (s_data.byte_valid),
        .last       (s_data.last),
        .m_ready    (m_ready),
        .stat       (stat),
        .cmd        (cmd),
        .s_ready    (s_ready),
        .m_valid    (m_valid)
    );

    sha1md_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .data_byte   (s_data.data_byte),
        .stat        (stat),
        .digest_word (digest_word)
    );

    // word index lives in the controller; last flag follows it
    assign m_data.digest_word = digest_word;
    assign m_data.word_last   = (cmd.out_idx == LAST_WORD);

endmodule

### design/sha1md_checker.sv
// Port-level checks for the SHA-1 digest block, bound to the top level.
// Depends on sha1md_pkg and sha1_message_digest.
module sha1md_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input sha1md_pkg::in_word_t  s_data,
    input logic                  m_valid,
    input logic                  m_ready,
    input sha1md_pkg::out_word_t m_data
);
    import sha1md_pkg::*;

    // stalled digest word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("digest word changed under stall");

    // intake and readout never overlap
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("s_ready during digest readout");

    // a message end drops s_ready at once, with no digest word out yet
    a_last_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.last |=> !s_ready && !m_valid)
        else $error("intake continued after last word");

    // readout ends on the flagged fifth word
    a_readout_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_data.word_last |=> !m_valid && s_ready)
        else $error("readout did not end after fifth word");

endmodule

bind sha1_message_digest sha1md_checker u_sha1md_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

### tb/sv/tb_top.sv
// Testbench for sha1_message_digest: drives message bytes, predicts each digest
// with its own SHA-1 model and checks every digest word as it comes out.
// Depends on sha1md_pkg and the sha1_message_digest RTL.
`timescale 1ns / 100ps

module tb_top;
    import sha1md_pkg::*;

    // No word moving for this many cycles means the block is hung.
    // The limit sits far above the slowest digest.
    localparam int unsigned HANG_LIMIT = 4000;
    // Quiet cycles after the last digest word, to catch stray output.
    localparam int unsigned DRAIN_CYCLES = 250;
    localparam int unsigned RANDOM_ITEMS = 150;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    // Predictor state: chaining words, block buffer, fill and length.
    logic [31:0] hash_chain [NUM_WORDS];
    logic [31:0] msg_block  [16];
    int unsigned block_fill;
    logic [60:0] msg_len;

    out_word_t   expected_digest [$];
    out_word_t   digest_head;

    int unsigned mismatch_count = 0;
    int unsigned items_sent     = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned recv_hold      = 0;
    bit          idle_on        = 1'b1;

    sha1_message_digest u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // ---------------------------------------------------------------
    // SHA-1 predictor
    // ---------------------------------------------------------------
    function automatic logic [31:0] rotl32(logic [31:0] x, int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // Big-endian lane write: byte 0 of the block lands in bits 31:24 of word 0.
    function automatic void put_lane(int unsigned pos, logic [7:0] v);
        msg_block[pos / 4][8 * (3 - pos % 4) +: 8] = v;
    endfunction

    function automatic void restart_chain();
        foreach (hash_chain[i]) hash_chain[i] = INIT_CHAIN[i];
        block_fill = 0;
        msg_len    = '0;
    endfunction

    // 80-round compression of msg_block into hash_chain.
    function automatic void compress_block();
        logic [31:0] sched [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++) sched[i] = msg_block[i];
        for (int i = 16; i < 80; i++)
            sched[i] = rotl32(sched[i-3] ^ sched[i-8] ^ sched[i-14] ^ sched[i-16], 1);
        a = hash_chain[0];
        b = hash_chain[1];
        c = hash_chain[2];
        d = hash_chain[3];
        e = hash_chain[4];
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d);
                k = 32'h5A827999;
            end else if (i < 40) begin
                f = b ^ c ^ d;
                k = 32'h6ED9EBA1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8F1BBCDC;
            end else begin
                f = b ^ c ^ d;
                k = 32'hCA62C1D6;
            end
            t = rotl32(a, 5) + f + e + k + sched[i];
            e = d;
            d = c;
            c = rotl32(b, 30);
            b = a;
            a = t;
        end
        hash_chain[0] += a;
        hash_chain[1] += b;
        hash_chain[2] += c;
        hash_chain[3] += d;
        hash_chain[4] += e;
    endfunction

    // Take one accepted input word; on last, queue the five digest words.
    function automatic void absorb_word(in_word_t w);
        logic [63:0] bit_len;
        out_word_t   dw;
        if (w.byte_valid) begin
            put_lane(block_fill, w.data_byte);
            msg_len    = msg_len + 1'b1;
            block_fill = block_fill + 1;
            if (block_fill == 64) begin
                compress_block();
                block_fill = 0;
            end
        end
        if (!w.last) return;

        // Padding: 0x80, zeros, length in the last two words.
        put_lane(block_fill, PAD_BYTE);
        for (int unsigned i = block_fill + 1; i < 64; i++) put_lane(i, 8'h00);
        if (block_fill >= 56) begin
            // no room for the length: spill into a second padding block
            compress_block();
            foreach (msg_block[i]) msg_block[i] = '0;
        end
        bit_len       = {msg_len, 3'b000};
        msg_block[14] = bit_len[63:32];
        msg_block[15] = bit_len[31:0];
        compress_block();

        for (int i = 0; i < NUM_WORDS; i++) begin
            dw.digest_word = hash_chain[i];
            dw.word_last   = (i == LAST_WORD);
            expected_digest.push_back(dw);
        end
        restart_chain();
    endfunction

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Output and input are sampled as they stood just before the edge.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_digest.size() == 0) begin
                report_mismatch("unexpected digest word", m_data.digest_word, '0);
            end else begin
                digest_head = expected_digest.pop_front();
                if (m_data.digest_word !== digest_head.digest_word)
                    report_mismatch("digest_word", m_data.digest_word,
                                    digest_head.digest_word);
                if (m_data.word_last !== digest_head.word_last)
                    report_mismatch("word_last", 32'(m_data.word_last),
                                    32'(digest_head.word_last));
            end
        end
    end

    // Receiver: ready most of the time, with occasional stall bursts.
    always @(posedge aclk) begin
        if (recv_hold != 0) begin
            m_ready <= 1'b0;
            recv_hold = recv_hold - 1;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            m_ready <= 1'b0;
            recv_hold = $urandom_range(0, 6);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Hang detector: counts cycles in which no word moves on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= HANG_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", HANG_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    // Send one input word; valid stays up after acceptance so back-to-back
    // words need only one assignment per edge.
    task automatic send_word(input logic vld, input logic [7:0] data, input logic lst);
        in_word_t w;
        w.byte_valid = vld;
        w.data_byte  = data;
        w.last       = lst;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        absorb_word(w);
        items_sent++;
    endtask

    // A message of len bytes; the end comes on the final byte or, with
    // empty_last, on a separate word with no byte. Empty words sprinkled in.
    task automatic send_message(input int unsigned len, input bit empty_last);
        for (int unsigned n = 0; n < len; n++) begin
            if ($urandom_range(0, 9) == 0)
                send_word(1'b0, 8'($urandom_range(0, 255)), 1'b0);
            send_word(1'b1, 8'($urandom_range(0, 255)), !empty_last && n == len - 1);
        end
        if (empty_last || len == 0) send_word(1'b0, 8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic test_empty_message();
        // last with no byte and nothing before: digest of the empty string
        send_word(1'b0, 8'hFF, 1'b1);
        // again, right after a digest, to see the chain was restored
        send_word(1'b0, 8'h00, 1'b1);
    endtask

    task automatic test_short_messages();
        // "abc", last flag on the final byte
        send_word(1'b1, 8'h61, 1'b0);
        send_word(1'b1, 8'h62, 1'b0);
        send_word(1'b1, 8'h63, 1'b1);
        // one-byte messages at both extremes of the byte
        send_word(1'b1, 8'h00, 1'b1);
        send_word(1'b1, 8'hFF, 1'b1);
        // bytes then an empty end word
        send_word(1'b1, 8'hFF, 1'b0);
        send_word(1'b1, 8'h80, 1'b0);
        send_word(1'b0, 8'h5A, 1'b1);
    endtask

    task automatic test_empty_words();
        // empty words between messages and inside one change nothing
        send_word(1'b0, 8'hFF, 1'b0);
        send_word(1'b1, 8'h7F, 1'b0);
        send_word(1'b0, 8'hAA, 1'b0);
        send_word(1'b0, 8'h55, 1'b0);
        send_word(1'b1, 8'h01, 1'b1);
        send_word(1'b0, 8'h00, 1'b0);
    endtask

    // Short messages alternate with ones that land near a block boundary,
    // where padding needs one or two blocks or the last byte fills a block.
    task automatic test_random_messages();
        int unsigned edge_len [4] = '{56, 64, 55, 63};
        int unsigned start, msg_idx, len;
        bit          empty_last;
        start   = items_sent;
        msg_idx = 0;
        while (items_sent - start < RANDOM_ITEMS) begin
            // last stretch runs with no idling at all
            idle_on = (items_sent - start < RANDOM_ITEMS - 40) && $urandom_range(0, 3) != 0;
            if (msg_idx % 2 == 1)
                len = edge_len[(msg_idx / 2) % 4];
            else
                len = $urandom_range(0, 15);
            empty_last = (len == 0) || $urandom_range(0, 2) == 0;
            send_message(len, empty_last);
            msg_idx++;
        end
    endtask

    initial begin
        restart_chain();
        foreach (msg_block[i]) msg_block[i] = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_message();
        test_short_messages();
        test_empty_words();
        test_random_messages();

        idle_on = 1'b0;
        s_valid <= 1'b0;
        while (expected_digest.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
